FILE: rtl/md_pkg.sv
package md_pkg;
  localparam int WORD_BITS = 64;
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);
  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_TRIAL,
    ST_DIV,
    ST_UPDATE,
    ST_PROD,
    ST_FINAL,
    ST_RED,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_round;
    logic trial;
    logic div_start;
    logic div_step;
    logic prod_start;
    logic prod_step;
    logic update;
    logic finalize;
    logic red_start;
    logic red_step;
    logic mul_start;
    logic mul_step;
    logic zero_out;
  } cmd_t;

  typedef struct packed {
    logic bot_gt1;
    logic rem_ge_bot;
    logic trial_last;
    logic cnt_done;
    logic prod_last;
  } stat_t;
endpackage

FILE: rtl/md_if.sv
interface md_in_if (input logic clk);
  logic valid;
  logic ready;
  md_pkg::word_t value;
  md_pkg::word_t divisor_value;
  md_pkg::word_t modulus;
  modport source (output valid, value, divisor_value, modulus, input ready);
  modport sink (input valid, value, divisor_value, modulus, output ready);
endinterface

interface md_out_if (input logic clk);
  logic valid;
  logic ready;
  md_pkg::word_t quotient_mod;
  modport source (output valid, quotient_mod, input ready);
  modport sink (input valid, quotient_mod, output ready);
endinterface

FILE: rtl/modular_division_core.sv
// The item is taken in idle. Each Euclid round then does repeated subtraction,
// or a full restoring division when the quotient is large, and a cofactor
// product; after the loop the value is reduced mod the modulus and multiplied
// by the inverse with double-and-add before the result shows.
// Throughput: one item at a time; the next is taken after the result leaves.
// Reset (rst, synchronous) returns the controller to idle; the datapath has no reset.
module modular_division_core (
  input logic clk,
  input logic rst,
  md_in_if.sink   in_ch,
  md_out_if.source out_ch
);
  import md_pkg::*;

  cmd_t cmd;
  stat_t stat;

  md_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  md_dp u_dp (
    .clk(clk), .cmd(cmd),
    .value(in_ch.value), .divisor_value(in_ch.divisor_value),
    .modulus(in_ch.modulus),
    .stat(stat), .quotient_mod(out_ch.quotient_mod)
  );
endmodule

FILE: rtl/md_ctrl.sv
module md_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  md_pkg::stat_t stat,
  output md_pkg::cmd_t  cmd
);
  import md_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (stat.bot_gt1) begin
          cmd.start_round = 1'b1;
          state_next = ST_TRIAL;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_TRIAL: begin
        if (!stat.rem_ge_bot) begin
          state_next = ST_UPDATE;
        end else if (stat.trial_last) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.trial = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.prod_start = 1'b1;
        state_next = ST_PROD;
      end
      // Accumulate the cofactor product; commit on the last multiplier byte.
      ST_PROD: begin
        cmd.prod_step = 1'b1;
        if (stat.prod_last) begin
          cmd.update = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_FINAL: begin
        cmd.finalize = 1'b1;
        cmd.red_start = 1'b1;
        state_next = ST_RED;
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (stat.cnt_done) begin
          cmd.mul_start = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.cnt_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/md_dp.sv
module md_dp (
  input  logic          clk,
  input  md_pkg::cmd_t  cmd,
  input  md_pkg::word_t value,
  input  md_pkg::word_t divisor_value,
  input  md_pkg::word_t modulus,
  output md_pkg::stat_t stat,
  output md_pkg::word_t quotient_mod
);
  import md_pkg::*;

  word_t top, bot, rem, c1, c2, m, v, mult, inv, acc, xr;
  word_t dq, dr;
  logic odd, mzero;
  logic [3:0] trials;
  logic [CNT_BITS-1:0] cnt;

  // Restoring divider step: one quotient bit per cycle.
  logic [WORD_BITS:0] dr_sh;
  logic [WORD_BITS:0] dr_sub;
  assign dr_sh = {dr, dq[WORD_BITS-1]};
  assign dr_sub = dr_sh - {1'b0, bot};

  // Modular add helpers for reduction and double-and-add.
  function automatic word_t add_mod(word_t x, word_t y, word_t mm);
    word_t d;
    d = mm - y;
    if (x >= d) return x - d;
    return x + y;
  endfunction

  word_t dbl, dbl_add, red_sh;
  assign dbl = add_mod(acc, acc, m);
  assign dbl_add = add_mod(dbl, xr, m);
  // Reduce v mod m bit-serially: acc = 2*acc + bit, compare.
  logic [WORD_BITS:0] red_w;
  assign red_w = {acc, v[WORD_BITS-1]};
  assign red_sh = (red_w >= {1'b0, m}) ? WORD_BITS'(red_w - {1'b0, m})
                                        : red_w[WORD_BITS-1:0];

  // Cofactor product mult * c1 + c2, one multiplier byte per cycle.
  word_t pacc, pc, q_new;
  logic [WORD_BITS+7:0] pp;
  assign pp = pc * mult[7:0];
  assign q_new = pacc + pp[WORD_BITS-1:0];

  assign stat.bot_gt1 = bot > word_t'(1);
  assign stat.rem_ge_bot = rem >= bot;
  assign stat.trial_last = trials == 4'd8;
  assign stat.cnt_done = cnt == CNT_BITS'(WORD_BITS - 1);
  assign stat.prod_last = (mult >> 8) == '0;
  assign quotient_mod = mzero ? '0 : acc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top <= modulus;
      bot <= divisor_value;
      m <= modulus;
      v <= value;
      mzero <= modulus == '0;
      c1 <= word_t'(1);
      c2 <= '0;
      odd <= 1'b0;
    end
    if (cmd.start_round) begin
      rem <= top - bot;
      mult <= word_t'(1);
      trials <= '0;
    end
    if (cmd.trial) begin
      rem <= rem - bot;
      mult <= mult + word_t'(1);
      trials <= trials + 4'd1;
    end
    if (cmd.div_start) begin
      dq <= top;
      dr <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      cnt <= cnt + CNT_BITS'(1);
      if (!dr_sub[WORD_BITS]) begin
        dr <= dr_sub[WORD_BITS-1:0];
        dq <= {dq[WORD_BITS-2:0], 1'b1};
      end else begin
        dr <= dr_sh[WORD_BITS-1:0];
        dq <= {dq[WORD_BITS-2:0], 1'b0};
      end
      if (stat.cnt_done) begin
        mult <= {dq[WORD_BITS-2:0], !dr_sub[WORD_BITS]};
        rem <= !dr_sub[WORD_BITS] ? dr_sub[WORD_BITS-1:0] : dr_sh[WORD_BITS-1:0];
      end
    end
    if (cmd.prod_start) begin
      pacc <= c2;
      pc <= c1;
    end
    if (cmd.prod_step) begin
      pacc <= q_new;
      pc <= pc << 8;
      mult <= mult >> 8;
    end
    if (cmd.update) begin
      c1 <= q_new;
      c2 <= c1;
      top <= bot;
      bot <= rem;
      odd <= !odd;
    end
    if (cmd.finalize) begin
      inv <= odd ? m - c1 : c1;
    end
    if (cmd.red_start) begin
      acc <= '0;
      cnt <= '0;
    end
    if (cmd.red_step) begin
      if (cmd.mul_start) begin
        xr <= red_sh;
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= red_sh;
        v <= {v[WORD_BITS-2:0], 1'b0};
        cnt <= cnt + CNT_BITS'(1);
      end
    end
    if (cmd.mul_step) begin
      acc <= inv[WORD_BITS-1] ? dbl_add : dbl;
      inv <= {inv[WORD_BITS-2:0], 1'b0};
      cnt <= cnt + CNT_BITS'(1);
    end
  end
endmodule

FILE: rtl/md_checker.sv
module md_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input md_pkg::word_t quotient_mod
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient_mod))
    else $error("result dropped");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready) else $error("no work gap");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not idle after result");
endmodule

bind modular_division_core md_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .quotient_mod(out_ch.quotient_mod)
);
